// ----- design/cthp_pkg.sv -----
// ----------------------------------------------------------------------------
// cthp_pkg
// shared types and constants for the chirality triple product histogram unit
// ----------------------------------------------------------------------------
package cthp_pkg;

   localparam int unsigned COORD_W = 16;
   localparam int unsigned DIST_W  = 16;
   localparam int unsigned ELEM_W  = 3;
   localparam int unsigned CHI_W   = 16;
   localparam int unsigned BINO_W  = 7;
   localparam int unsigned CNT_W   = 32;
   localparam int unsigned DEN_W   = 3 * DIST_W;
   localparam int unsigned TP_W    = 51;
   localparam int unsigned QUO_W   = 15;
   localparam int unsigned NUM_W   = DEN_W + QUO_W;
   localparam int unsigned Q14_ONE = 16384;

   typedef struct packed {
      logic                      valid;
      logic                      moved;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic [DIST_W-1:0]         d;
   } entry_type;

   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } div_ctl_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CROSS,
      ST_DOT,
      ST_SUM,
      ST_ABS,
      ST_CHK,
      ST_DIV,
      ST_BIN,
      ST_RD_E,
      ST_WR_E,
      ST_RD_T,
      ST_WR_T,
      ST_DONE
   } state_type;

endpackage

// ----- design/chirality_triple_product_histogram_unit.sv -----
// ----------------------------------------------------------------------------
// chirality_triple_product_histogram_unit
// keeps the three nearest neighbors of an atom, forms the normalized triple
// product and counts it in per-element and total histograms
// ----------------------------------------------------------------------------
//  channel  direction  handshake            word
//  req_     in         req_valid/req_stall  one neighbor of the current atom
//  rsp_     out        rsp_valid/rsp_stall  chirality and updated bin counts
//
//  a neighbor word is taken every cycle while the atom is collected
//  the last word of an atom holds req_stall high through the arithmetic,
//  bin and histogram states, and also while the bit-serial divider runs
//  after reset the histogram memory is cleared, one entry a cycle, all
//  (MAX_ELEMENTS + 1) * NUM_BINS entries, with req_stall high
//  a held result only stalls the block when the next one is ready
// ----------------------------------------------------------------------------
module chirality_triple_product_histogram_unit #(
   parameter int unsigned NUM_BINS     = 100,
   parameter int unsigned MAX_ELEMENTS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [cthp_pkg::COORD_W-1:0] req_vec_x,
   input  logic signed [cthp_pkg::COORD_W-1:0] req_vec_y,
   input  logic signed [cthp_pkg::COORD_W-1:0] req_vec_z,
   input  logic [cthp_pkg::DIST_W-1:0]         req_distance,
   input  logic                                req_neighbor_present,
   input  logic [cthp_pkg::ELEM_W-1:0]         req_element_index,
   input  logic                                req_last_of_atom,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [cthp_pkg::CHI_W-1:0]   rsp_chirality,
   output logic [cthp_pkg::BINO_W-1:0]         rsp_bin_index,
   output logic                                rsp_had_three,
   output logic [cthp_pkg::CNT_W-1:0]          rsp_element_bin_count,
   output logic [cthp_pkg::CNT_W-1:0]          rsp_total_bin_count,
   output logic [cthp_pkg::CNT_W-1:0]          rsp_atom_count
);
   import cthp_pkg::*;

   localparam int unsigned DEPTH  = (MAX_ELEMENTS + 1) * NUM_BINS;
   localparam int unsigned ADDR_W = $clog2(DEPTH);
   localparam int unsigned BIN_W  = $clog2(NUM_BINS);
   localparam int unsigned PROD_W = CHI_W + $clog2(NUM_BINS + 1);
   localparam int unsigned RAW_W  = PROD_W - 15;

   state_type state_ff, state_in;

   // neighbor chain
   entry_type new_entry;
   entry_type link0, link1, link2, unused_tail;
   entry_type near0, near1, near2;
   logic      accept;
   logic      shift_en;
   logic      cells_clear;

   assign accept = req_valid && !req_stall;
   assign shift_en = accept && req_neighbor_present && (req_distance != '0);

   always_comb begin
      new_entry.valid = 1'b1;
      new_entry.moved = 1'b0;
      new_entry.x = req_vec_x;
      new_entry.y = req_vec_y;
      new_entry.z = req_vec_z;
      new_entry.d = req_distance;
   end

   assign link0 = new_entry;

   cthp_cell u_cell0 (
      .clock(clock), .reset(reset), .clear(cells_clear), .shift_en(shift_en),
      .in_entry(link0), .out_entry(link1), .held(near0)
   );
   cthp_cell u_cell1 (
      .clock(clock), .reset(reset), .clear(cells_clear), .shift_en(shift_en),
      .in_entry(link1), .out_entry(link2), .held(near1)
   );
   cthp_cell u_cell2 (
      .clock(clock), .reset(reset), .clear(cells_clear), .shift_en(shift_en),
      .in_entry(link2), .out_entry(unused_tail), .held(near2)
   );

   // arithmetic path
   logic signed [31:0]      p0, p1, p2, p3, p4, p5;
   logic signed [32:0]      cx_ff, cy_ff, cz_ff;
   logic signed [48:0]      t0_ff, t1_ff, t2_ff;
   logic [2*DIST_W-1:0]     dd_ff;
   logic signed [TP_W-1:0]  tp_ff;
   logic [DEN_W-1:0]        den_ff;
   logic [TP_W-1:0]         mag_ff;
   logic                    neg_ff;
   logic                    three_ff;
   logic [ELEM_W-1:0]       elem_ff;
   logic signed [CHI_W-1:0] chi_ff;
   logic [BIN_W-1:0]        bin_ff;
   logic [NUM_W-1:0]        div_num;
   logic [QUO_W-1:0]        div_quo;
   div_ctl_type             div_ctl;
   logic                    div_start;
   logic [CHI_W-1:0]        chi_off;
   logic [PROD_W-1:0]       bin_prod;
   logic [RAW_W-1:0]        bin_raw;
   logic                    elem_ok;

   assign p0 = 32'(near0.y) * 32'(near1.z);
   assign p1 = 32'(near0.z) * 32'(near1.y);
   assign p2 = 32'(near0.z) * 32'(near1.x);
   assign p3 = 32'(near0.x) * 32'(near1.z);
   assign p4 = 32'(near0.x) * 32'(near1.y);
   assign p5 = 32'(near0.y) * 32'(near1.x);

   assign div_num = NUM_W'({mag_ff[DEN_W-1:0], 14'b0}) + NUM_W'(den_ff[DEN_W-1:1]);

   cthp_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num),
      .den(den_ff), .quo(div_quo), .ctl(div_ctl)
   );

   assign chi_off = CHI_W'(chi_ff) + CHI_W'(Q14_ONE);
   assign bin_prod = PROD_W'(chi_off) * PROD_W'(NUM_BINS);
   assign bin_raw = bin_prod[PROD_W-1:15];
   assign elem_ok = (32'(elem_ff) < MAX_ELEMENTS);

   // histogram memory
   logic [CNT_W-1:0]  hist_mem [DEPTH];
   logic [CNT_W-1:0]  rd_data_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;
   logic [CNT_W-1:0]  wr_data;
   logic              wr_en;
   logic [ADDR_W-1:0] addr_e, addr_t;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [CNT_W-1:0]  ecount_ff, ecount_in;
   logic [CNT_W-1:0]  tcount_ff, tcount_in;
   logic [CNT_W-1:0]  atoms_ff, atoms_in;

   assign addr_e = ADDR_W'(32'(elem_ff) * NUM_BINS + 32'(bin_ff));
   assign addr_t = ADDR_W'(MAX_ELEMENTS * NUM_BINS + 32'(bin_ff));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         hist_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= hist_mem[rd_addr];
   end

   // result register
   logic rsp_valid_ff, rsp_valid_in;
   logic load_rsp;

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      ecount_in = ecount_ff;
      tcount_in = tcount_ff;
      atoms_in = atoms_ff;
      cells_clear = 1'b0;
      div_start = 1'b0;
      load_rsp = 1'b0;
      wr_en = 1'b0;
      wr_addr = addr_e;
      wr_data = rd_data_ff + 1'b1;
      rd_addr = addr_e;
      req_stall = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept && req_last_of_atom) begin
               state_in = ST_CROSS;
            end
         end
         ST_CROSS: state_in = ST_DOT;
         ST_DOT:   state_in = ST_SUM;
         ST_SUM:   state_in = ST_ABS;
         ST_ABS:   state_in = ST_CHK;
         ST_CHK: begin
            if (three_ff && (mag_ff < TP_W'(den_ff))) begin
               div_start = 1'b1;
               state_in = ST_DIV;
            end else begin
               state_in = ST_BIN;
            end
         end
         ST_DIV: begin
            if (div_ctl.done) begin
               state_in = ST_BIN;
            end
         end
         ST_BIN: state_in = ST_RD_E;
         ST_RD_E: begin
            rd_addr = addr_e;
            if (elem_ok) begin
               state_in = ST_WR_E;
            end else begin
               ecount_in = '0;
               state_in = ST_RD_T;
            end
         end
         ST_WR_E: begin
            wr_en = 1'b1;
            wr_addr = addr_e;
            ecount_in = rd_data_ff + 1'b1;
            state_in = ST_RD_T;
         end
         ST_RD_T: begin
            rd_addr = addr_t;
            state_in = ST_WR_T;
         end
         ST_WR_T: begin
            wr_en = 1'b1;
            wr_addr = addr_t;
            tcount_in = rd_data_ff + 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp = 1'b1;
               atoms_in = atoms_ff + 1'b1;
               cells_clear = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         atoms_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         atoms_ff <= atoms_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ecount_ff <= ecount_in;
      tcount_ff <= tcount_in;
      if (accept && req_last_of_atom) begin
         elem_ff <= req_element_index;
      end
      cx_ff <= 33'(p0) - 33'(p1);
      cy_ff <= 33'(p2) - 33'(p3);
      cz_ff <= 33'(p4) - 33'(p5);
      t0_ff <= 49'(cx_ff) * 49'(near2.x);
      t1_ff <= 49'(cy_ff) * 49'(near2.y);
      t2_ff <= 49'(cz_ff) * 49'(near2.z);
      dd_ff <= 32'(near0.d) * 32'(near1.d);
      tp_ff <= TP_W'(t0_ff) + TP_W'(t1_ff) + TP_W'(t2_ff);
      den_ff <= DEN_W'(dd_ff) * DEN_W'(near2.d);
      neg_ff <= tp_ff[TP_W-1];
      mag_ff <= tp_ff[TP_W-1] ? TP_W'(-tp_ff) : TP_W'(tp_ff);
      three_ff <= near2.valid;
      if (state_ff == ST_CHK) begin
         if (!three_ff) begin
            chi_ff <= '0;
         end else if (neg_ff) begin
            chi_ff <= -CHI_W'(Q14_ONE);
         end else begin
            chi_ff <= CHI_W'(Q14_ONE);
         end
      end else if (div_ctl.done) begin
         chi_ff <= neg_ff ? -CHI_W'(div_quo) : CHI_W'(div_quo);
      end
      if (state_ff == ST_BIN) begin
         if (32'(bin_raw) >= NUM_BINS) begin
            bin_ff <= BIN_W'(NUM_BINS - 1);
         end else begin
            bin_ff <= BIN_W'(bin_raw);
         end
      end
      if (load_rsp) begin
         rsp_chirality <= chi_ff;
         rsp_bin_index <= BINO_W'(bin_ff);
         rsp_had_three <= three_ff;
         rsp_element_bin_count <= ecount_ff;
         rsp_total_bin_count <= tcount_ff;
         rsp_atom_count <= atoms_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> req_stall)
      else $error("word taken during histogram clear");

   a_short_list_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_had_three |-> rsp_chirality == '0)
      else $error("nonzero chirality with fewer than three neighbors");

   a_chi_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_chirality <= 16'sd16384) && (rsp_chirality >= -16'sd16384))
      else $error("chirality out of range");

   a_div_only_when_waiting: assert property (@(posedge clock) disable iff (reset)
      div_ctl.busy |-> state_ff == ST_DIV)
      else $error("divider running outside its state");

endmodule

// ----- design/cthp_cell.sv -----
// ----------------------------------------------------------------------------
// cthp_cell
// one slot of the nearest neighbor insertion chain
// ----------------------------------------------------------------------------
module cthp_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                clear,
   input  logic                shift_en,
   input  cthp_pkg::entry_type in_entry,
   output cthp_pkg::entry_type out_entry,
   output cthp_pkg::entry_type held
);
   import cthp_pkg::*;

   entry_type held_ff;
   entry_type held_in;
   logic      take;

   // a displaced entry is older than everything below it
   always_comb begin
      take = in_entry.valid &&
             (in_entry.moved || !held_ff.valid || (in_entry.d < held_ff.d));
      held_in = held_ff;
      out_entry = in_entry;
      if (take) begin
         held_in = in_entry;
         held_in.moved = 1'b0;
         out_entry = held_ff;
         out_entry.moved = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         held_ff.valid <= 1'b0;
      end else if (shift_en) begin
         held_ff <= held_in;
      end
   end

   assign held = held_ff;

endmodule

// ----- design/cthp_divider.sv -----
// ----------------------------------------------------------------------------
// cthp_divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module cthp_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [cthp_pkg::NUM_W-1:0]    num,
   input  logic [cthp_pkg::DEN_W-1:0]    den,
   output logic [cthp_pkg::QUO_W-1:0]    quo,
   output cthp_pkg::div_ctl_type         ctl
);
   import cthp_pkg::*;

   localparam int unsigned CNT_BITS = $clog2(QUO_W + 1);

   logic [DEN_W-1:0]    rem_ff, rem_in;
   logic [QUO_W-1:0]    low_ff, low_in;
   logic [QUO_W-1:0]    quo_ff, quo_in;
   logic [DEN_W-1:0]    den_ff;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [DEN_W:0]      trial;
   logic [DEN_W:0]      diff;

   always_comb begin
      trial = {rem_ff, low_ff[QUO_W-1]};
      diff = trial - {1'b0, den_ff};
      rem_in = rem_ff;
      low_in = low_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = num[NUM_W-1:QUO_W];
         low_in = num[QUO_W-1:0];
         quo_in = '0;
         cnt_in = CNT_BITS'(QUO_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         low_in = {low_ff[QUO_W-2:0], 1'b0};
         if (!diff[DEN_W]) begin
            rem_in = diff[DEN_W-1:0];
            quo_in = {quo_ff[QUO_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DEN_W-1:0];
            quo_in = {quo_ff[QUO_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
      if (start) begin
         den_ff <= den;
      end
   end

   assign quo = quo_ff;
   assign ctl.start = start;
   assign ctl.busy = busy_ff;
   assign ctl.done = done_ff;

endmodule

// ----- tb/sv/tb_chirality_triple_product_histogram_unit.sv -----
// ----------------------------------------------------------------------------
// tb_chirality_triple_product_histogram_unit
// streams neighbor words for many atoms into the unit, predicts the
// chirality, bin and histogram counts of every atom and checks each result
// ----------------------------------------------------------------------------
module tb_chirality_triple_product_histogram_unit;
   import cthp_pkg::*;

   localparam int unsigned NBINS = 100;
   localparam int unsigned NELEM = 8;

   class chirality_scoreboard;
      typedef struct {
         logic signed [CHI_W-1:0] chi;
         logic [BINO_W-1:0]       bin;
         logic                    three;
         logic [CNT_W-1:0]        elem_cnt;
         logic [CNT_W-1:0]        total_cnt;
         logic [CNT_W-1:0]        atoms;
      } atom_outcome_t;

      atom_outcome_t  pending[$];
      int             errors;
      longint         nx[3], ny[3], nz[3];
      longint unsigned nd[3];
      int             kept;
      int unsigned    hist[(NELEM + 1) * NBINS];
      int unsigned    atoms_binned;

      function new();
         errors = 0;
         kept = 0;
         atoms_binned = 0;
         foreach (hist[i]) hist[i] = 0;
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      function void keep_nearest(longint x, longint y, longint z, longint unsigned d);
         int pos;
         int k;
         pos = 0;
         while (pos < kept && nd[pos] <= d) pos++;
         if (pos >= 3) return;
         k = (kept < 3) ? kept : 2;
         while (k > pos) begin
            nx[k] = nx[k-1]; ny[k] = ny[k-1]; nz[k] = nz[k-1]; nd[k] = nd[k-1];
            k--;
         end
         nx[pos] = x; ny[pos] = y; nz[pos] = z; nd[pos] = d;
         if (kept < 3) kept++;
      endfunction

      function longint chirality_q14();
         longint cx, cy, cz, tp;
         longint unsigned mag, den, q;
         if (kept < 3) return 0;
         cx = ny[0] * nz[1] - nz[0] * ny[1];
         cy = nz[0] * nx[1] - nx[0] * nz[1];
         cz = nx[0] * ny[1] - ny[0] * nx[1];
         tp = cx * nx[2] + cy * ny[2] + cz * nz[2];
         den = nd[0] * nd[1] * nd[2];
         if (den == 0) return 0;
         mag = (tp < 0) ? longint'(-tp) : longint'(tp);
         if (mag >= den) q = Q14_ONE;
         else q = ((mag << 14) + (den >> 1)) / den;
         if (q > Q14_ONE) q = Q14_ONE;
         return (tp < 0) ? -longint'(q) : longint'(q);
      endfunction

      function void note_word(logic signed [15:0] x, logic signed [15:0] y,
                              logic signed [15:0] z, logic [15:0] d, logic present,
                              logic [2:0] elem, logic last);
         atom_outcome_t o;
         longint chi;
         longint unsigned bin;
         int idx;
         if (present && d != 0) keep_nearest(longint'(x), longint'(y), longint'(z), d);
         if (!last) return;
         o.three = (kept >= 3);
         chi = chirality_q14();
         bin = (longint'(chi + Q14_ONE) * NBINS) >> 15;
         if (bin >= NBINS) bin = NBINS - 1;
         o.elem_cnt = 0;
         if (elem < NELEM) begin
            idx = elem * NBINS + int'(bin);
            hist[idx]++;
            o.elem_cnt = hist[idx];
         end
         idx = NELEM * NBINS + int'(bin);
         hist[idx]++;
         atoms_binned++;
         o.chi = chi[15:0];
         o.bin = bin[6:0];
         o.total_cnt = hist[idx];
         o.atoms = atoms_binned;
         pending = {pending, o};
         kept = 0;
      endfunction

      task check_result(atom_outcome_t r);
         atom_outcome_t e;
         if (pending.size() == 0) begin
            report("result with no atom outstanding");
            return;
         end
         e = pending.pop_front();
         if (r.chi !== e.chi) report($sformatf("chirality %0d exp %0d", r.chi, e.chi));
         if (r.bin !== e.bin) report($sformatf("bin %0d exp %0d", r.bin, e.bin));
         if (r.three !== e.three) report($sformatf("had_three %0b exp %0b", r.three, e.three));
         if (r.elem_cnt !== e.elem_cnt)
            report($sformatf("element count %0d exp %0d", r.elem_cnt, e.elem_cnt));
         if (r.total_cnt !== e.total_cnt)
            report($sformatf("total count %0d exp %0d", r.total_cnt, e.total_cnt));
         if (r.atoms !== e.atoms) report($sformatf("atom count %0d exp %0d", r.atoms, e.atoms));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [COORD_W-1:0] req_vec_x = '0;
   logic signed [COORD_W-1:0] req_vec_y = '0;
   logic signed [COORD_W-1:0] req_vec_z = '0;
   logic [DIST_W-1:0] req_distance = '0;
   logic req_neighbor_present = 1'b0;
   logic [ELEM_W-1:0] req_element_index = '0;
   logic req_last_of_atom = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [CHI_W-1:0] rsp_chirality;
   logic [BINO_W-1:0] rsp_bin_index;
   logic rsp_had_three;
   logic [CNT_W-1:0] rsp_element_bin_count;
   logic [CNT_W-1:0] rsp_total_bin_count;
   logic [CNT_W-1:0] rsp_atom_count;

   chirality_scoreboard sb = new();
   bit quiet = 1'b0;
   int words_sent = 0;

   chirality_triple_product_histogram_unit #(.NUM_BINS(NBINS), .MAX_ELEMENTS(NELEM)) u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_vec_x(req_vec_x), .req_vec_y(req_vec_y), .req_vec_z(req_vec_z),
      .req_distance(req_distance), .req_neighbor_present(req_neighbor_present),
      .req_element_index(req_element_index), .req_last_of_atom(req_last_of_atom),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_chirality(rsp_chirality), .rsp_bin_index(rsp_bin_index),
      .rsp_had_three(rsp_had_three), .rsp_element_bin_count(rsp_element_bin_count),
      .rsp_total_bin_count(rsp_total_bin_count), .rsp_atom_count(rsp_atom_count)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // accepted words on both channels
   always @(posedge clock) begin
      chirality_scoreboard::atom_outcome_t r;
      if (!reset && req_valid && !req_stall)
         sb.note_word(req_vec_x, req_vec_y, req_vec_z, req_distance,
                      req_neighbor_present, req_element_index, req_last_of_atom);
      if (!reset && rsp_valid && !rsp_stall) begin
         r.chi = rsp_chirality;
         r.bin = rsp_bin_index;
         r.three = rsp_had_three;
         r.elem_cnt = rsp_element_bin_count;
         r.total_cnt = rsp_total_bin_count;
         r.atoms = rsp_atom_count;
         sb.check_result(r);
      end
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_word(int x, int y, int z, int d, bit present, int elem, bit last);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_vec_x = x[15:0];
      req_vec_y = y[15:0];
      req_vec_z = z[15:0];
      req_distance = d[15:0];
      req_neighbor_present = present;
      req_element_index = elem[2:0];
      req_last_of_atom = last;
      #1;
      while (req_stall) begin
         @(negedge clock);
         #1;
      end
      @(negedge clock);
      words_sent++;
   endtask

   task automatic send_random_atom();
      int len;
      bit noisy;
      int x, y, z, d;
      len = $urandom_range(1, 7);
      noisy = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < len; i++) begin
         if (noisy || $urandom_range(0, 9) == 0) begin
            x = $urandom; y = $urandom; z = $urandom;
            d = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 65535);
            send_word(x, y, z, d, $urandom_range(0, 1), $urandom_range(0, 7), i == len - 1);
         end else begin
            x = $signed($urandom_range(0, 20000)) - 10000;
            y = $signed($urandom_range(0, 20000)) - 10000;
            z = $signed($urandom_range(0, 20000)) - 10000;
            d = (x < 0 ? -x : x) + (y < 0 ? -y : y) + (z < 0 ? -z : z);
            d = (d * $urandom_range(6, 10)) / 10;
            if (d > 65535) d = 65535;
            if (d == 0) d = 1;
            if ($urandom_range(0, 7) == 0) d = 4096;
            send_word(x, y, z, d, 1'b1, $urandom_range(0, 7), i == len - 1);
         end
      end
   endtask

   // receiver stall bursts
   initial begin
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 10)) @(negedge clock);
         end
         rsp_stall = 1'b0;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // no neighbors, ignored zero distance, fewer than three
      send_word(0, 0, 0, 0, 1'b0, 0, 1'b1);
      send_word(100, 200, 300, 0, 1'b1, 1, 1'b1);
      send_word(1024, 0, 0, 1024, 1'b1, 2, 1'b0);
      send_word(0, 1024, 0, 1024, 1'b1, 2, 1'b1);
      // right-handed and left-handed unit frames, exactly one
      send_word(1024, 0, 0, 1024, 1'b1, 3, 1'b0);
      send_word(0, 1024, 0, 1024, 1'b1, 3, 1'b0);
      send_word(0, 0, 1024, 1024, 1'b1, 3, 1'b1);
      send_word(0, 1024, 0, 1024, 1'b1, 4, 1'b0);
      send_word(1024, 0, 0, 1024, 1'b1, 4, 1'b0);
      send_word(0, 0, 1024, 1024, 1'b1, 4, 1'b1);
      // equal distances keep the earlier neighbors
      send_word(500, 100, -30, 600, 1'b1, 5, 1'b0);
      send_word(-200, 400, 90, 600, 1'b1, 5, 1'b0);
      send_word(70, -300, 450, 600, 1'b1, 5, 1'b0);
      send_word(9000, 9000, 9000, 600, 1'b1, 5, 1'b0);
      send_word(0, 0, 0, 0, 1'b0, 5, 1'b1);
      // extreme coordinates, tiny and largest distance
      send_word(32767, -32768, 32767, 1, 1'b1, 6, 1'b0);
      send_word(-32768, 32767, 32767, 65535, 1'b1, 6, 1'b0);
      send_word(32767, 32767, -32768, 65535, 1'b1, 6, 1'b0);
      send_word(-32768, -32768, -32768, 65535, 1'b1, 7, 1'b1);
      // rounding near a half step
      send_word(1000, 30, 0, 3000, 1'b1, 7, 1'b0);
      send_word(20, 1000, 7, 3001, 1'b1, 7, 1'b0);
      send_word(3, 11, 1000, 3002, 1'b1, 7, 1'b1);

      while (words_sent < 750) begin
         if (words_sent > 700) quiet = 1'b1;
         send_random_atom();
         if (words_sent > 350 && words_sent < 360) begin
            req_valid = 1'b0;
            while (sb.pending.size() != 0) @(negedge clock);
         end
      end
      req_valid = 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #40000000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// ----- files.f -----
design/cthp_pkg.sv
design/cthp_cell.sv
design/cthp_divider.sv
design/chirality_triple_product_histogram_unit.sv
tb/sv/tb_chirality_triple_product_histogram_unit.sv
